/* hw/rtl/ipmac_pkg.sv */
// Shared constants, codes and types of the IP/MAC binding table.
package ipmac_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

    localparam int FUNC_W   = 2;
    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int LINE_W   = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;
    localparam int REMOVED_W = 7;
    localparam int MAXENT_W = 7;
    localparam int AGE_W    = 16;
    localparam int AGE_LIM_W = 22;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int KEY_W    = IP_W + MAC_W;

    localparam int MINUTE_SECONDS = 60;
    localparam logic [MAXENT_W-1:0] MAX_ENTRIES_RST = 7'd50;
    localparam logic [AGE_W-1:0]    MAX_AGE_RST     = 16'd60;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE     = 1'd1;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_AGE    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic ip_eq;
        logic mac_eq;
        logic aged;
    } cmp_res_t;

endpackage

/* hw/rtl/ipmac_ram.sv */
// Generic simple dual-port RAM with registered read.
module ipmac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/ipmac_cmp.sv */
// Shared compare unit: key match and age test for one table entry.
module ipmac_cmp (
    input  logic [ipmac_pkg::IP_W-1:0]      entry_ip,
    input  logic [ipmac_pkg::MAC_W-1:0]     entry_mac,
    input  logic [ipmac_pkg::TIME_W-1:0]    entry_time,
    input  logic [ipmac_pkg::IP_W-1:0]      key_ip,
    input  logic [ipmac_pkg::MAC_W-1:0]     key_mac,
    input  logic [ipmac_pkg::TIME_W-1:0]    now,
    input  logic [ipmac_pkg::AGE_LIM_W-1:0] age_limit,
    output ipmac_pkg::cmp_res_t             res
);

    logic [ipmac_pkg::TIME_W-1:0] elapsed;

    assign elapsed    = now - entry_time;
    assign res.ip_eq  = (entry_ip == key_ip);
    assign res.mac_eq = (entry_mac == key_mac);
    assign res.aged   = (elapsed > ipmac_pkg::TIME_W'(age_limit));

endmodule

/* hw/rtl/ip_mac_binding_table_with_aging_unit.sv */
// Top level: IP/MAC binding table with aging, scanned by one compare unit.
// Every operation scans all 64 slots through the table RAMs, then the finish state
// updates the table (add, remove) and loads the result register; that step holds
// while an earlier result word still waits for m_ready. A new input word is
// accepted only in the idle state, after the previous operation has finished.
// Reset (synchronous, aresetn low) clears all valid bits, the sequencer and the
// result valid flag, and restores max_entries to 50 and max_age_minutes to 60.
module ip_mac_binding_table_with_aging_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ipmac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ipmac_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ipmac_pkg::FUNC_W-1:0]         s_func,
    input  logic [ipmac_pkg::IP_W-1:0]           s_ip_address,
    input  logic [ipmac_pkg::MAC_W-1:0]          s_mac_address,
    input  logic [ipmac_pkg::LINE_W-1:0]         s_line_value,
    input  logic [ipmac_pkg::TIME_W-1:0]         s_now_seconds,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ipmac_pkg::STATUS_W-1:0]       m_status,
    output logic [ipmac_pkg::SLOT_W-1:0]         m_slot_index,
    output logic [ipmac_pkg::REMOVED_W-1:0]      m_removed_count,
    output logic [ipmac_pkg::LINE_W-1:0]         m_found_line,
    output logic [ipmac_pkg::TIME_W-1:0]         m_found_time
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam int SW = ipmac_pkg::SLOT_W;
    localparam int CW = ipmac_pkg::CNT_W;

    logic [1:0] state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic pv_reg, pv_next;
    logic [SW-1:0] pslot_reg, pslot_next;
    logic [ipmac_pkg::TABLE_SLOTS-1:0] valid_reg, valid_next;

    logic [ipmac_pkg::MAXENT_W-1:0] max_entries_reg, max_entries_next;
    logic [ipmac_pkg::AGE_W-1:0] max_age_reg, max_age_next;

    logic [ipmac_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [ipmac_pkg::IP_W-1:0] ip_reg, ip_next;
    logic [ipmac_pkg::MAC_W-1:0] mac_reg, mac_next;
    logic [ipmac_pkg::LINE_W-1:0] line_reg, line_next;
    logic [ipmac_pkg::TIME_W-1:0] now_reg, now_next;
    logic [ipmac_pkg::AGE_LIM_W-1:0] lim_reg, lim_next;

    logic hit_reg, hit_next;
    logic [SW-1:0] hit_slot_reg, hit_slot_next;
    logic free_reg, free_next;
    logic [SW-1:0] free_slot_reg, free_slot_next;
    logic [ipmac_pkg::REMOVED_W-1:0] rm_reg, rm_next;
    logic [ipmac_pkg::LINE_W-1:0] fline_reg, fline_next;
    logic [ipmac_pkg::TIME_W-1:0] ftime_reg, ftime_next;

    logic m_valid_reg, m_valid_next;
    logic [ipmac_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [ipmac_pkg::REMOVED_W-1:0] removed_reg, removed_next;
    logic [ipmac_pkg::LINE_W-1:0] oline_reg, oline_next;
    logic [ipmac_pkg::TIME_W-1:0] otime_reg, otime_next;

    logic ram_re;
    logic key_we, line_we, time_we;
    logic [SW-1:0] ram_waddr;
    logic [ipmac_pkg::KEY_W-1:0] key_dout;
    logic [ipmac_pkg::LINE_W-1:0] line_dout;
    logic [ipmac_pkg::TIME_W-1:0] time_dout;
    ipmac_pkg::cmp_res_t cmp_res;
    logic ent_v, conflict;

    ipmac_ram #(.WIDTH(ipmac_pkg::KEY_W), .DEPTH(ipmac_pkg::TABLE_SLOTS)) u_key_ram (
        .aclk(aclk), .we(key_we), .waddr(ram_waddr), .wdata({ip_reg, mac_reg}),
        .re(ram_re), .raddr(cnt_reg[SW-1:0]), .rdata(key_dout)
    );

    ipmac_ram #(.WIDTH(ipmac_pkg::LINE_W), .DEPTH(ipmac_pkg::TABLE_SLOTS)) u_line_ram (
        .aclk(aclk), .we(line_we), .waddr(ram_waddr), .wdata(line_reg),
        .re(ram_re), .raddr(cnt_reg[SW-1:0]), .rdata(line_dout)
    );

    ipmac_ram #(.WIDTH(ipmac_pkg::TIME_W), .DEPTH(ipmac_pkg::TABLE_SLOTS)) u_time_ram (
        .aclk(aclk), .we(time_we), .waddr(ram_waddr), .wdata(now_reg),
        .re(ram_re), .raddr(cnt_reg[SW-1:0]), .rdata(time_dout)
    );

    ipmac_cmp u_cmp (
        .entry_ip   (key_dout[ipmac_pkg::KEY_W-1:ipmac_pkg::MAC_W]),
        .entry_mac  (key_dout[ipmac_pkg::MAC_W-1:0]),
        .entry_time (time_dout),
        .key_ip     (ip_reg),
        .key_mac    (mac_reg),
        .now        (now_reg),
        .age_limit  (lim_reg),
        .res        (cmp_res)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign ram_re  = (state_reg == ST_SCAN) && (cnt_reg != CW'(ipmac_pkg::TABLE_SLOTS));
    assign ent_v   = valid_reg[pslot_reg];
    assign conflict = ent_v && (cmp_res.ip_eq ^ cmp_res.mac_eq);

    always_comb begin
        max_entries_next = max_entries_reg;
        max_age_next     = max_age_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                ipmac_pkg::REG_MAX_ENTRIES: begin
                    max_entries_next = cfg_data[ipmac_pkg::MAXENT_W-1:0];
                end
                ipmac_pkg::REG_MAX_AGE: begin
                    max_age_next = cfg_data[ipmac_pkg::AGE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pv_next        = pv_reg;
        pslot_next     = pslot_reg;
        valid_next     = valid_reg;
        func_next      = func_reg;
        ip_next        = ip_reg;
        mac_next       = mac_reg;
        line_next      = line_reg;
        now_next       = now_reg;
        lim_next       = lim_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        rm_next        = rm_reg;
        fline_next     = fline_reg;
        ftime_next     = ftime_reg;
        m_valid_next   = m_valid_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        removed_next   = removed_reg;
        oline_next     = oline_reg;
        otime_next     = otime_reg;
        key_we         = 1'b0;
        line_we        = 1'b0;
        time_we        = 1'b0;
        ram_waddr      = hit_slot_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // evaluate the slot whose RAM data arrived this cycle
        if (pv_reg) begin
            case (func_reg)
                ipmac_pkg::FUNC_ADD: begin
                    if (conflict) begin
                        valid_next[pslot_reg] = 1'b0;
                        rm_next = rm_reg + 1'b1;
                    end
                    if (ent_v && !conflict && cmp_res.ip_eq && !hit_reg) begin
                        hit_next      = 1'b1;
                        hit_slot_next = pslot_reg;
                    end
                    if ((!ent_v || conflict) && !free_reg
                        && ({1'b0, pslot_reg} < max_entries_reg)) begin
                        free_next      = 1'b1;
                        free_slot_next = pslot_reg;
                    end
                end
                ipmac_pkg::FUNC_AGE: begin
                    if (ent_v && cmp_res.aged) begin
                        valid_next[pslot_reg] = 1'b0;
                        rm_next = rm_reg + 1'b1;
                    end
                end
                default: begin
                    if (ent_v && cmp_res.ip_eq && !hit_reg) begin
                        hit_next      = 1'b1;
                        hit_slot_next = pslot_reg;
                        fline_next    = line_dout;
                        ftime_next    = time_dout;
                    end
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    func_next  = s_func;
                    ip_next    = s_ip_address;
                    mac_next   = s_mac_address;
                    line_next  = s_line_value;
                    now_next   = s_now_seconds;
                    lim_next   = ipmac_pkg::AGE_LIM_W'(max_age_reg)
                                 * ipmac_pkg::AGE_LIM_W'(ipmac_pkg::MINUTE_SECONDS);
                    cnt_next   = '0;
                    pv_next    = 1'b0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    rm_next    = '0;
                    fline_next = '0;
                    ftime_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg != CW'(ipmac_pkg::TABLE_SLOTS)) begin
                    cnt_next   = cnt_reg + 1'b1;
                    pv_next    = 1'b1;
                    pslot_next = cnt_reg[SW-1:0];
                end else begin
                    pv_next    = 1'b0;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    status_next  = ipmac_pkg::STATUS_OK;
                    slot_next    = '0;
                    removed_next = rm_reg;
                    oline_next   = '0;
                    otime_next   = '0;
                    case (func_reg)
                        ipmac_pkg::FUNC_ADD: begin
                            if (hit_reg) begin
                                time_we   = 1'b1;
                                slot_next = hit_slot_reg;
                            end else if (free_reg) begin
                                ram_waddr = free_slot_reg;
                                key_we    = 1'b1;
                                line_we   = 1'b1;
                                time_we   = 1'b1;
                                valid_next[free_slot_reg] = 1'b1;
                                slot_next = free_slot_reg;
                            end else begin
                                status_next = ipmac_pkg::STATUS_FULL;
                            end
                        end
                        ipmac_pkg::FUNC_REMOVE: begin
                            if (hit_reg) begin
                                valid_next[hit_slot_reg] = 1'b0;
                                slot_next    = hit_slot_reg;
                                removed_next = ipmac_pkg::REMOVED_W'(1);
                            end else begin
                                status_next = ipmac_pkg::STATUS_NOT_FOUND;
                            end
                        end
                        ipmac_pkg::FUNC_FIND: begin
                            if (hit_reg) begin
                                slot_next  = hit_slot_reg;
                                oline_next = fline_reg;
                                otime_next = ftime_reg;
                            end else begin
                                status_next = ipmac_pkg::STATUS_NOT_FOUND;
                            end
                        end
                        default: begin
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            pv_reg          <= 1'b0;
            valid_reg       <= '0;
            m_valid_reg     <= 1'b0;
            max_entries_reg <= ipmac_pkg::MAX_ENTRIES_RST;
            max_age_reg     <= ipmac_pkg::MAX_AGE_RST;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            pv_reg          <= pv_next;
            valid_reg       <= valid_next;
            m_valid_reg     <= m_valid_next;
            max_entries_reg <= max_entries_next;
            max_age_reg     <= max_age_next;
        end
    end

    always_ff @(posedge aclk) begin
        pslot_reg     <= pslot_next;
        func_reg      <= func_next;
        ip_reg        <= ip_next;
        mac_reg       <= mac_next;
        line_reg      <= line_next;
        now_reg       <= now_next;
        lim_reg       <= lim_next;
        hit_reg       <= hit_next;
        hit_slot_reg  <= hit_slot_next;
        free_reg      <= free_next;
        free_slot_reg <= free_slot_next;
        rm_reg        <= rm_next;
        fline_reg     <= fline_next;
        ftime_reg     <= ftime_next;
        status_reg    <= status_next;
        slot_reg      <= slot_next;
        removed_reg   <= removed_next;
        oline_reg     <= oline_next;
        otime_reg     <= otime_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_slot_index    = slot_reg;
    assign m_removed_count = removed_reg;
    assign m_found_line    = oline_reg;
    assign m_found_time    = otime_reg;

endmodule

/* hw/rtl/ipmac_chk.sv */
// Port-level checker for the binding table, bound to the top level.
module ipmac_chk (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic [ipmac_pkg::STATUS_W-1:0]       m_status,
    input logic [ipmac_pkg::SLOT_W-1:0]         m_slot_index,
    input logic [ipmac_pkg::REMOVED_W-1:0]      m_removed_count,
    input logic [ipmac_pkg::LINE_W-1:0]         m_found_line,
    input logic [ipmac_pkg::TIME_W-1:0]         m_found_time
);

    // busy after accepting a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted back to back");

    // failed operations report no slot and no found data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ipmac_pkg::STATUS_OK) |->
            m_slot_index == '0 && m_found_line == '0 && m_found_time == '0)
        else $error("failed operation carries slot or data");

    // never more removals than slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_removed_count <= ipmac_pkg::REMOVED_W'(ipmac_pkg::TABLE_SLOTS)
            && (m_status == ipmac_pkg::STATUS_OK || m_status == ipmac_pkg::STATUS_FULL
                || m_status == ipmac_pkg::STATUS_NOT_FOUND))
        else $error("bad removed count or status");

    // hold a stalled result word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot_index)
            && $stable(m_removed_count) && $stable(m_found_line) && $stable(m_found_time))
        else $error("stalled result changed");

endmodule

bind ip_mac_binding_table_with_aging_unit ipmac_chk u_ipmac_chk (.*);
